FILE: design/grord_pkg.sv
// shared constants for the gas rate-of-rise detector
// register map, default parameter values and fixed field widths; no dependencies
package grord_pkg;

  // default parameter values
  localparam int unsigned HISTORY_DEPTH_DEF = 4;
  localparam int unsigned SAMPLE_BITS_DEF   = 12;

  // millisecond tick width
  localparam int unsigned TIME_W = 32;

  // configuration port
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WARMUP    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_START     = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd3;

  // register reset values
  localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd10000;
  localparam logic [TIME_W-1:0] WARMUP_RESET = 32'd60000;
  localparam logic [TIME_W-1:0] START_RESET  = 32'd0;
  localparam int unsigned       THRESHOLD_RESET = 300;

endpackage

FILE: design/grord_ref_search.sv
// reference search over the sample history ring
// picks the newest entry at least a window old; uses grord_pkg
module grord_ref_search #(
  parameter int unsigned HISTORY_DEPTH = grord_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS   = grord_pkg::SAMPLE_BITS_DEF
) (
  input  logic [grord_pkg::TIME_W-1:0] now_i,
  input  logic [grord_pkg::TIME_W-1:0] window_i,
  input  logic [HISTORY_DEPTH-1:0]     entry_valid_i,
  input  logic [grord_pkg::TIME_W-1:0] entry_time_i   [HISTORY_DEPTH],
  input  logic [SAMPLE_BITS-1:0]       entry_sample_i [HISTORY_DEPTH],
  output logic                         found_o,
  output logic [SAMPLE_BITS-1:0]       ref_sample_o
);
  import grord_pkg::*;

  logic [TIME_W-1:0]        age [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] eligible;
  logic [HISTORY_DEPTH-1:0] winner;

  // age is taken modulo 2^32
  always_comb begin
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      age[i]      = now_i - entry_time_i[i];
      eligible[i] = entry_valid_i[i] && (age[i] >= window_i);
    end
  end

  // pairwise compares: an entry wins if no other eligible one is newer,
  // equal stamps go to the lower slot
  always_comb begin
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      winner[i] = eligible[i];
      for (int j = 0; j < HISTORY_DEPTH; j++) begin
        if (j < i) begin
          if (eligible[j] && !(entry_time_i[i] > entry_time_i[j])) winner[i] = 1'b0;
        end else if (j > i) begin
          if (eligible[j] && (entry_time_i[i] < entry_time_i[j])) winner[i] = 1'b0;
        end
      end
    end
  end

  // winner is one-hot when anything is eligible
  always_comb begin
    ref_sample_o = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (winner[i]) ref_sample_o = ref_sample_o | entry_sample_i[i];
    end
  end

  assign found_o = |eligible;

endmodule

FILE: design/gas_rate_of_rise_detector.sv
// top level of the gas rate-of-rise detector
// stream in/out, apb-style configuration; uses grord_pkg and grord_ref_search
// an accepted input beat passes through the input register, then the result register, to its
//   result beat; throughput: one beat per cycle while the result stream is not stalled
// the rate rests on the single-pass search over the history ring between the two registers
// reset (rst_ni low, asynchronous): history emptied, alarm memory cleared, pipeline empty,
//   configuration back to window 10000, warm-up 60000, start 0, threshold 300
// a failed read leaves no result beat and clears the alarm edge memory
module gas_rate_of_rise_detector #(
  parameter int unsigned HISTORY_DEPTH = grord_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS   = grord_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned S_TDATA_W =
    ((SAMPLE_BITS + grord_pkg::TIME_W + 7) / 8) * 8,
  localparam int unsigned M_TDATA_W =
    ((2 * SAMPLE_BITS + grord_pkg::TIME_W + 5 + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // sample_raw, time_ms, zero fill
  input  logic [S_TDATA_W-1:0]             s_axis_tdata,
  // read_ok
  input  logic [0:0]                       s_axis_tuser,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // rise, reference_sample, reference_found, warming_up, warmup_left_ms,
  // alarm, alarm_onset, zero fill
  output logic [M_TDATA_W-1:0]             m_axis_tdata,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [grord_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [grord_pkg::APB_DATA_W-1:0] pwdata,
  output logic [grord_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready
);
  import grord_pkg::*;

  localparam int unsigned SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned OUT_W  = 2 * SAMPLE_BITS + TIME_W + 5;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0]      window_q, warmup_q, start_q;
  logic [SAMPLE_BITS-1:0] thr_q;
  logic                   cfg_wr;
  logic [REG_IDX_W-1:0]   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[REG_IDX_W+1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
      warmup_q <= WARMUP_RESET;
      start_q  <= START_RESET;
      thr_q    <= SAMPLE_BITS'(THRESHOLD_RESET);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WINDOW:    window_q <= pwdata;
        REG_WARMUP:    warmup_q <= pwdata;
        REG_START:     start_q  <= pwdata;
        REG_THRESHOLD: thr_q    <= pwdata[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    case (cfg_idx)
      REG_WINDOW:    prdata = window_q;
      REG_WARMUP:    prdata = warmup_q;
      REG_START:     prdata = start_q;
      REG_THRESHOLD: prdata = APB_DATA_W'(thr_q);
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  logic                   in_valid_q;
  logic [SAMPLE_BITS-1:0] in_sample_q;
  logic [TIME_W-1:0]      in_time_q;
  logic                   in_ok_q;
  logic                   out_valid_q, out_valid_d;
  logic [M_TDATA_W-1:0]   out_data_q, out_data_d;
  logic                   out_free;
  logic                   advance;
  logic                   in_take;

  // the result register is free when empty or being drained this cycle
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_sample_q <= s_axis_tdata[SAMPLE_BITS-1:0];
      in_time_q   <= s_axis_tdata[SAMPLE_BITS+TIME_W-1:SAMPLE_BITS];
      in_ok_q     <= s_axis_tuser[0];
    end
  end

  // ---------------------------------------------------------------------------
  // history ring: valid bit per slot, write pointer wraps at the depth
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0]   ring_sample_q [HISTORY_DEPTH];
  logic [TIME_W-1:0]        ring_time_q   [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] ring_valid_q;
  logic [SLOT_W-1:0]        slot_q, slot_d;
  logic                     alarm_prev_q, alarm_prev_d;
  logic                     push;

  // only a good read that leaves the input register enters the ring
  assign push = advance && in_ok_q;

  always_comb begin
    if (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) begin
      slot_d = '0;
    end else begin
      slot_d = slot_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_valid_q <= '0;
      slot_q       <= '0;
    end else if (push) begin
      ring_valid_q[slot_q] <= 1'b1;
      slot_q               <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ring_sample_q[slot_q] <= in_sample_q;
      ring_time_q[slot_q]   <= in_time_q;
    end
  end

  // ---------------------------------------------------------------------------
  // per-beat evaluation
  // ---------------------------------------------------------------------------
  logic                          srch_found;
  logic [SAMPLE_BITS-1:0]        srch_ref;
  logic [TIME_W-1:0]             elapsed;
  logic                          warming;
  logic [TIME_W-1:0]             left_ms;
  logic                          found;
  logic [SAMPLE_BITS-1:0]        ref_sample;
  logic signed [SAMPLE_BITS:0]   rise;
  logic                          alarm;
  logic                          onset;

  grord_ref_search #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_search (
    .now_i          (in_time_q),
    .window_i       (window_q),
    .entry_valid_i  (ring_valid_q),
    .entry_time_i   (ring_time_q),
    .entry_sample_i (ring_sample_q),
    .found_o        (srch_found),
    .ref_sample_o   (srch_ref)
  );

  always_comb begin
    // warm-up is judged on wrapping elapsed time
    elapsed    = in_time_q - start_q;
    warming    = elapsed < warmup_q;
    left_ms    = warming ? (warmup_q - elapsed) : '0;
    found      = !warming && srch_found;
    ref_sample = found ? srch_ref : in_sample_q;
    rise       = found ? ($signed({1'b0, in_sample_q}) - $signed({1'b0, ref_sample})) : '0;
    // a negative rise never raises the alarm
    alarm      = found && !rise[SAMPLE_BITS] && (rise[SAMPLE_BITS-1:0] >= thr_q);
    onset      = alarm && !alarm_prev_q;
  end

  // a failed read clears the edge memory
  assign alarm_prev_d = advance ? (in_ok_q && alarm) : alarm_prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_prev_q <= 1'b0;
    end else begin
      alarm_prev_q <= alarm_prev_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  assign out_valid_d = push || (out_valid_q && !m_axis_tready);
  assign out_data_d  = M_TDATA_W'({onset, alarm, left_ms, warming, found, ref_sample, rise});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a result beat only appears from a good read leaving the input register
  a_beat_from_good_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(in_valid_q && in_ok_q))
    else $error("result beat without a good read");

  // alarm needs a reference, and a reference is never reported while warming up
  a_alarm_needs_ref: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((!out_data_q[OUT_W-2] || out_data_q[2*SAMPLE_BITS+1])
                     && !(out_data_q[2*SAMPLE_BITS+1] && out_data_q[2*SAMPLE_BITS+2])))
    else $error("alarm or reference while not allowed");

  // onset only with alarm
  a_onset_with_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[OUT_W-1]) |-> out_data_q[OUT_W-2])
    else $error("alarm onset without alarm");

  // a stalled result beat keeps its payload
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> $stable(out_data_q))
    else $error("result payload changed under stall");

endmodule
